// ===== rtl/qau_pkg.sv =====
// Shared types, operation codes and constant tables of the quaternion arithmetic unit.
package qau_pkg;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_SCALE  = 4'd3,
        OP_DIV    = 4'd4,
        OP_CONJ   = 4'd5,
        OP_NEG    = 4'd6,
        OP_INV    = 4'd7,
        OP_NORM   = 4'd8,
        OP_SQNORM = 4'd9,
        OP_IMAG   = 4'd10
    } qau_op_t;

    // Execution class decided by the front end.
    typedef enum logic [3:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_SCALE,
        K_DIV,
        K_CONJ,
        K_NEG,
        K_INV,
        K_NORM,
        K_SQNORM,
        K_ZERO
    } qau_kind_t;

    typedef struct packed {
        qau_kind_t        kind;
        logic             imag;
        logic [3:0][31:0] a;
        logic [3:0][31:0] b;
        logic [31:0]      f;
    } qau_item_t;

    localparam int QDEPTH = 4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Hamilton product terms: lane l, term k sits at index 4*l+k, as a[AIDX] * b[BIDX].
    localparam logic [1:0] MUL_AIDX [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd0, 2'd2, 2'd3, 2'd1,
        2'd0, 2'd3, 2'd1, 2'd2
    };
    localparam logic [1:0] MUL_BIDX [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd2, 2'd1
    };
    // Terms that are subtracted.
    localparam logic [15:0] MUL_NEG = 16'b1000_1000_1000_1110;

endpackage

// ===== rtl/qau_if.sv =====
// Request and response channel interfaces of the quaternion arithmetic unit.
interface qau_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [31:0] a_w;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_w;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] factor;

    modport source (
        output valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor,
        input  ready
    );
    modport sink (
        input  valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor,
        output ready
    );
endinterface

interface qau_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] r_w;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic        imaginary;
    logic [1:0]  status;

    modport source (
        output valid, r_w, r_x, r_y, r_z, imaginary, status,
        input  ready
    );
    modport sink (
        input  valid, r_w, r_x, r_y, r_z, imaginary, status,
        output ready
    );
endinterface

// ===== rtl/qau_front.sv =====
// Front end: accepts request items and classifies them into the work queue.
module qau_front (
    qau_req_if.sink          req,
    input  logic             full,
    output logic             push,
    output qau_pkg::qau_item_t item
);
    import qau_pkg::*;

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        unique case (req.opcode)
            OP_ADD:    item.kind = K_ADD;
            OP_SUB:    item.kind = K_SUB;
            OP_MUL:    item.kind = K_MUL;
            OP_SCALE:  item.kind = K_SCALE;
            OP_DIV:    item.kind = K_DIV;
            OP_CONJ:   item.kind = K_CONJ;
            OP_NEG:    item.kind = K_NEG;
            OP_INV:    item.kind = K_INV;
            OP_NORM:   item.kind = K_NORM;
            OP_SQNORM: item.kind = K_SQNORM;
            default:   item.kind = K_ZERO;   // imagtest and unused codes
        endcase
        item.imag = (req.a_w == 32'd0);
        item.a[0] = req.a_w;
        item.a[1] = req.a_x;
        item.a[2] = req.a_y;
        item.a[3] = req.a_z;
        item.b[0] = req.b_w;
        item.b[1] = req.b_x;
        item.b[2] = req.b_y;
        item.b[3] = req.b_z;
        item.f    = req.factor;
    end
endmodule

// ===== rtl/qau_fifo.sv =====
// Short queue between the front end and the execution back end.
module qau_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qau_pkg::qau_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output qau_pkg::qau_item_t q_item
);
    import qau_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    qau_item_t         mem_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       count_reg;

    assign full    = (count_reg == (PW+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid && count_reg <= (PW+1)'(QDEPTH))
        else $error("queue read while empty");
endmodule

// ===== rtl/qau_back.sv =====
// Execution back end: multiplier stage, combine/iterate stage and output register.
module qau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  qau_pkg::qau_item_t q_item,
    output logic               pop,
    qau_rsp_if.source          rsp
);
    import qau_pkg::*;

    localparam int NW = 32 + FRAC_BITS;                 // dividend magnitude width
    localparam int DW = 65 - FRAC_BITS;                 // divisor width
    localparam int LW = (66 - FRAC_BITS > 33 + FRAC_BITS) ? 66 - FRAC_BITS : 33 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int SQ_STEPS = 32;
    localparam logic signed [LW-1:0] HI = LW'(32'sh7FFF_FFFF);
    localparam logic signed [LW-1:0] LO = LW'($signed(32'h8000_0000));

    // ---------------- stage 1: products ----------------
    logic                     s1_valid_reg;
    qau_kind_t                s1_kind_reg;
    logic                     s1_imag_reg;
    logic signed [31:0]       s1_a_reg [4];
    logic signed [31:0]       s1_b_reg [4];
    logic signed [31:0]       s1_f_reg;
    logic signed [63:0]       s1_p_reg [16];
    logic signed [31:0]       mx [16];
    logic signed [31:0]       my [16];

    logic s1_adv, s1_free, s2_free, s2_done, out_load;

    assign s1_free = !s1_valid_reg || s1_adv;
    assign pop     = q_valid && s1_free;

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            mx[n] = $signed(q_item.a[MUL_AIDX[n]]);
            my[n] = $signed(q_item.b[MUL_BIDX[n]]);
        end
        if (q_item.kind == K_SCALE)
        begin
            for (int l = 0; l < 4; l++)
            begin
                mx[4*l] = $signed(q_item.a[l]);
                my[4*l] = $signed(q_item.f);
            end
        end
        else if (q_item.kind == K_INV || q_item.kind == K_NORM || q_item.kind == K_SQNORM)
        begin
            for (int l = 0; l < 4; l++)
            begin
                mx[4*l] = $signed(q_item.a[l]);
                my[4*l] = $signed(q_item.a[l]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_kind_reg <= q_item.kind;
            s1_imag_reg <= q_item.imag;
            s1_f_reg    <= $signed(q_item.f);
            for (int l = 0; l < 4; l++)
            begin
                s1_a_reg[l] <= $signed(q_item.a[l]);
                s1_b_reg[l] <= $signed(q_item.b[l]);
            end
            for (int n = 0; n < 16; n++)
            begin
                s1_p_reg[n] <= mx[n] * my[n];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // ---------------- stage 2: combine, or iterate ----------------
    logic [64:0]              ssum;
    logic [DW-1:0]            s_den;
    logic                     big;
    logic signed [65:0]       mulsum [4];
    logic signed [65:0]       term;
    logic signed [LW-1:0]     lane_val [4];
    logic [31:0]              a_mag [4];
    logic [31:0]              f_mag;
    logic                     ld_div0, ld_div, ld_sqrt;
    logic [CW-1:0]            ld_cnt;
    logic [DW-1:0]            ld_den;
    logic [3:0]               ld_neg;

    always_comb
    begin
        ssum = '0;
        for (int l = 0; l < 4; l++)
        begin
            ssum = ssum + 65'({1'b0, s1_p_reg[4*l]});
        end
        big   = ssum[64];
        s_den = DW'(ssum >> FRAC_BITS);

        for (int l = 0; l < 4; l++)
        begin
            mulsum[l] = '0;
            for (int k = 0; k < 4; k++)
            begin
                term = 66'(s1_p_reg[4*l+k]);
                if (MUL_NEG[4*l+k])
                begin
                    mulsum[l] = mulsum[l] - term;
                end
                else
                begin
                    mulsum[l] = mulsum[l] + term;
                end
            end
            a_mag[l] = s1_a_reg[l][31] ? 32'(-s1_a_reg[l]) : 32'(s1_a_reg[l]);
        end
        f_mag = s1_f_reg[31] ? 32'(-s1_f_reg) : 32'(s1_f_reg);

        for (int l = 0; l < 4; l++)
        begin
            unique case (s1_kind_reg)
                K_ADD:    lane_val[l] = LW'(s1_a_reg[l]) + LW'(s1_b_reg[l]);
                K_SUB:    lane_val[l] = LW'(s1_a_reg[l]) - LW'(s1_b_reg[l]);
                K_MUL:    lane_val[l] = LW'(mulsum[l] >>> FRAC_BITS);
                K_SCALE:  lane_val[l] = LW'(s1_p_reg[4*l] >>> FRAC_BITS);
                K_CONJ:   lane_val[l] = (l == 0) ? LW'(s1_a_reg[l]) : -LW'(s1_a_reg[l]);
                K_NEG:    lane_val[l] = -LW'(s1_a_reg[l]);
                K_SQNORM: lane_val[l] = (l == 0) ? LW'(ssum >> FRAC_BITS) : '0;
                K_NORM:   lane_val[l] = (l == 0 && big) ? LW'({1'b1, 32'd0}) : '0;
                default:  lane_val[l] = '0;
            endcase
        end

        ld_div0 = (s1_kind_reg == K_DIV && s1_f_reg == 32'sd0)
               || (s1_kind_reg == K_INV && s_den == '0);
        ld_div  = (s1_kind_reg == K_DIV || s1_kind_reg == K_INV) && !ld_div0;
        ld_sqrt = (s1_kind_reg == K_NORM) && !big;
        ld_cnt  = ld_div ? CW'(NW) : (ld_sqrt ? CW'(SQ_STEPS) : '0);
        ld_den  = (s1_kind_reg == K_DIV) ? DW'(f_mag) : s_den;
        for (int l = 0; l < 4; l++)
        begin
            if (s1_kind_reg == K_DIV)
            begin
                ld_neg[l] = s1_a_reg[l][31] ^ s1_f_reg[31];
            end
            else
            begin
                ld_neg[l] = (l == 0) ? s1_a_reg[l][31] : !s1_a_reg[l][31];
            end
        end
    end

    logic                     s2_valid_reg;
    logic [CW-1:0]            s2_cnt_reg;
    logic                     s2_div_reg;
    logic                     s2_sqrt_reg;
    qau_kind_t                s2_kind_reg;
    logic                     s2_imag_reg;
    logic                     s2_div0_reg;
    logic signed [LW-1:0]     s2_val_reg [4];
    logic [DW-1:0]            s2_den_reg;
    logic [NW-1:0]            s2_num_reg [4];
    logic [DW-1:0]            s2_rem_reg [4];
    logic [3:0]               s2_neg_reg;
    logic [63:0]              s2_rad_reg;
    logic [33:0]              s2_srem_reg;
    logic [31:0]              s2_root_reg;

    // one restoring-division step per lane and one square-root digit per cycle
    logic [DW:0]              d_trial [4];
    logic                     d_ge [4];
    logic [NW-1:0]            s2_num_next [4];
    logic [DW-1:0]            s2_rem_next [4];
    logic [35:0]              q_cur;
    logic [35:0]              q_trial;
    logic                     q_ge;
    logic [33:0]              s2_srem_next;
    logic [31:0]              s2_root_next;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            d_trial[l]     = {s2_rem_reg[l], s2_num_reg[l][NW-1]};
            d_ge[l]        = d_trial[l] >= {1'b0, s2_den_reg};
            s2_rem_next[l] = d_ge[l] ? DW'(d_trial[l] - {1'b0, s2_den_reg}) : DW'(d_trial[l]);
            s2_num_next[l] = {s2_num_reg[l][NW-2:0], d_ge[l]};
        end
        q_cur        = {s2_srem_reg, s2_rad_reg[63:62]};
        q_trial      = {2'b00, s2_root_reg, 2'b01};
        q_ge         = q_cur >= q_trial;
        s2_srem_next = q_ge ? 34'(q_cur - q_trial) : 34'(q_cur);
        s2_root_next = {s2_root_reg[30:0], q_ge};
    end

    assign s2_done = s2_valid_reg && (s2_cnt_reg == '0);
    assign s2_free = !s2_valid_reg || out_load;
    assign s1_adv  = s1_valid_reg && s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_cnt_reg   <= '0;
            s2_div_reg   <= 1'b0;
            s2_sqrt_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= 1'b1;
            s2_cnt_reg   <= ld_cnt;
            s2_div_reg   <= ld_div;
            s2_sqrt_reg  <= ld_sqrt;
        end
        else
        begin
            if (out_load)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_cnt_reg != '0)
            begin
                s2_cnt_reg <= s2_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_imag_reg <= s1_imag_reg;
            s2_div0_reg <= ld_div0;
            s2_den_reg  <= ld_den;
            s2_neg_reg  <= ld_neg;
            s2_rad_reg  <= ssum[63:0];
            s2_srem_reg <= '0;
            s2_root_reg <= '0;
            for (int l = 0; l < 4; l++)
            begin
                s2_val_reg[l] <= lane_val[l];
                s2_num_reg[l] <= {a_mag[l], {FRAC_BITS{1'b0}}};
                s2_rem_reg[l] <= '0;
            end
        end
        else if (s2_cnt_reg != '0)
        begin
            for (int l = 0; l < 4; l++)
            begin
                s2_num_reg[l] <= s2_num_next[l];
                s2_rem_reg[l] <= s2_rem_next[l];
            end
            s2_rad_reg  <= {s2_rad_reg[61:0], 2'b00};
            s2_srem_reg <= s2_srem_next;
            s2_root_reg <= s2_root_next;
        end
    end

    // ---------------- output register: clip and status ----------------
    logic signed [LW-1:0]     fin [4];
    logic signed [LW-1:0]     quo [4];
    logic [3:0]               lane_sat;
    logic [31:0]              lane_out [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            quo[l] = LW'({1'b0, s2_num_reg[l]});
            if (s2_div_reg)
            begin
                fin[l] = s2_neg_reg[l] ? -quo[l] : quo[l];
            end
            else if (s2_sqrt_reg)
            begin
                fin[l] = (l == 0) ? LW'({1'b0, s2_root_reg}) : '0;
            end
            else
            begin
                fin[l] = s2_val_reg[l];
            end
            if (fin[l] > HI)
            begin
                lane_sat[l] = 1'b1;
                lane_out[l] = 32'h7FFF_FFFF;
            end
            else if (fin[l] < LO)
            begin
                lane_sat[l] = 1'b1;
                lane_out[l] = 32'h8000_0000;
            end
            else
            begin
                lane_sat[l] = 1'b0;
                lane_out[l] = 32'(fin[l]);
            end
        end
    end

    logic        out_valid_reg;
    logic [31:0] out_r_reg [4];
    logic        out_imag_reg;
    logic [1:0]  out_status_reg;

    assign out_load = s2_done && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int l = 0; l < 4; l++)
            begin
                out_r_reg[l] <= lane_out[l];
            end
            out_imag_reg   <= s2_imag_reg;
            out_status_reg <= s2_div0_reg ? ST_DIV0 : ((|lane_sat) ? ST_SAT : ST_OK);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.r_w       = out_r_reg[0];
    assign rsp.r_x       = out_r_reg[1];
    assign rsp.r_y       = out_r_reg[2];
    assign rsp.r_z       = out_r_reg[3];
    assign rsp.imaginary = out_imag_reg;
    assign rsp.status    = out_status_reg;

    a_cnt_steps: assert property (@(posedge clk) disable iff (!rst_n)
        s2_cnt_reg != '0 |=> s2_cnt_reg == CW'($past(s2_cnt_reg) - 1'b1))
        else $error("iteration counter skipped or reloaded mid-item");

    a_iter_owner: assert property (@(posedge clk) disable iff (!rst_n)
        s2_cnt_reg != '0 |-> s2_valid_reg && (s2_div_reg || s2_sqrt_reg) && !out_load)
        else $error("iteration running without an owning item");

    a_div0_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && s2_div0_reg |-> (s2_kind_reg == K_DIV || s2_kind_reg == K_INV))
        else $error("divide-by-zero status on a non-dividing operation");
endmodule

// ===== rtl/quaternion_arith_unit.sv =====
// Top level of the quaternion arithmetic unit: front end, work queue and back end.
//
// Usage:
//   req carries one item per valid/ready handshake: opcode, quaternions a and b, and the
//   scalar factor, all signed fixed point with FRAC_BITS fraction bits. rsp returns one
//   item per request, in order: r_w..r_z, the imaginary flag (a_w is zero) and status
//   (ok, divide by zero, saturated).
//   Add, sub, mul, scale, conj, neg, sqnorm and the zero-result codes pass from the queue
//   through the product stage, the combine stage and the output register. Div and
//   inverse iterate in the combine stage in a one-bit-per-cycle divider (four lanes in
//   parallel); norm iterates in a two-bits-per-cycle square root. Those are the only items
//   that hold the back end; all others flow at one item per cycle unless rsp stalls.
//   A four-entry queue between the classifier and the execution pipeline keeps req.ready
//   high while the back end iterates or rsp is stalled, until the queue fills.
//   When rsp.ready is low the finished item holds in the output register and the
//   pipeline behind it stops; nothing is dropped.
//   Reset (rst_n low, asynchronous) empties the queue and all pipeline stages.
module quaternion_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    qau_req_if.sink   req,
    qau_rsp_if.source rsp
);
    import qau_pkg::*;

    logic      push;
    logic      full;
    qau_item_t push_item;
    logic      pop;
    logic      q_valid;
    qau_item_t q_item;

    // decode the opcode, flag an imaginary operand, pack the item
    qau_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (push_item)
    );

    // decouples request acceptance from execution stalls
    qau_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // multiplier array, combine / iterate stage, clipping output register
    qau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .rsp     (rsp)
    );
endmodule
